// ===== hdl/assert_macros.svh =====
// Assertion macros shared by the encoder RTL.
// No dependencies; compile with NO_ASSERTIONS defined to drop all checks.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef NO_ASSERTIONS
`define ASSERT_AT(name, clk, rst_n, prop) \
  name: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error("assertion failed");
`define ASSERT_NEVER(name, clk, rst_n, expr) \
  name: assert property (@(posedge clk) disable iff (!rst_n) !(expr)) else $error("forbidden condition");
`else
`define ASSERT_AT(name, clk, rst_n, prop)
`define ASSERT_NEVER(name, clk, rst_n, expr)
`endif

`endif

// ===== hdl/scce_pkg.sv =====
// Shared types and constants for the serial CRC codeword encoder.
// No dependencies.
package scce_pkg;

  localparam int unsigned MaxWidth = 32;
  localparam int unsigned WidthW   = 6;
  localparam int unsigned ShiftW   = 5;
  localparam int unsigned QDepth   = 4;
  localparam int unsigned QPtrW    = 2;
  localparam int unsigned QCntW    = 3;

  typedef enum logic [1:0] {
    CfgGenPoly  = 2'd0,
    CfgCrcWidth = 2'd1
  } cfg_idx_e;

  // One accepted bit as handed from front to back.
  typedef struct packed {
    logic                   data;
    logic                   last;
    logic [MaxWidth-1:0]    rem_al;  // remainder, MSB aligned to bit 31
    logic [WidthW-1:0]      width;   // effective width, 1..32
  } entry_t;

  typedef struct packed {
    logic push;
    logic full;
  } q_wr_t;

endpackage

// ===== hdl/scce_front.sv =====
// Front end: config registers and the serial LFSR remainder update.
// Depends on scce_pkg.
module scce_front (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     cfg_valid_i,
  output logic                     cfg_ready_o,
  input  logic [1:0]               cfg_index_i,
  input  logic [31:0]              cfg_data_i,
  input  logic                     push_i,
  input  logic                     data_bit_i,
  input  logic                     last_bit_i,
  input  logic                     q_full_i,
  output logic                     q_push_o,
  output scce_pkg::entry_t         q_entry_o
);
  import scce_pkg::*;

  logic [MaxWidth-1:0] gen_q, gen_d;
  logic [WidthW-1:0]   width_q, width_d;
  logic [MaxWidth-1:0] rem_q, rem_d;

  logic [WidthW-1:0]   w_eff;
  logic [WidthW-1:0]   w_m1;
  logic [WidthW-1:0]   sh_amt;
  logic [MaxWidth:0]   mask_ext;
  logic [MaxWidth-1:0] mask;
  logic [MaxWidth-1:0] rem_m;
  logic [MaxWidth-1:0] rem_nx;
  logic                fb;
  logic                accept;

  assign cfg_ready_o = 1'b1;

  always_comb begin
    gen_d   = gen_q;
    width_d = width_q;
    if (cfg_valid_i) begin
      case (cfg_index_i)
        CfgGenPoly:  gen_d   = cfg_data_i;
        CfgCrcWidth: width_d = cfg_data_i[WidthW-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    if (width_q == '0) begin
      w_eff = WidthW'(1);
    end else if (width_q > WidthW'(MaxWidth)) begin
      w_eff = WidthW'(MaxWidth);
    end else begin
      w_eff = width_q;
    end
    w_m1     = w_eff - WidthW'(1);
    mask_ext = ((MaxWidth+1)'(1) << w_eff) - (MaxWidth+1)'(1);
    mask     = mask_ext[MaxWidth-1:0];
    rem_m    = rem_q & mask;
    fb       = rem_m[w_m1[ShiftW-1:0]] ^ data_bit_i;
    rem_nx   = (rem_m << 1) & mask;
    if (fb) begin
      rem_nx = rem_nx ^ (gen_q & mask);
    end
    sh_amt   = WidthW'(MaxWidth) - w_eff;
  end

  assign accept   = push_i && !q_full_i;
  assign q_push_o = accept;

  always_comb begin
    q_entry_o.data   = data_bit_i;
    q_entry_o.last   = last_bit_i;
    q_entry_o.rem_al = rem_nx << sh_amt[ShiftW-1:0];
    q_entry_o.width  = w_eff;
  end

  always_comb begin
    rem_d = rem_q;
    if (accept) begin
      rem_d = last_bit_i ? '0 : rem_nx;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      gen_q   <= MaxWidth'(3);
      width_q <= WidthW'(4);
      rem_q   <= '0;
    end else begin
      gen_q   <= gen_d;
      width_q <= width_d;
      rem_q   <= rem_d;
    end
  end

endmodule

// ===== hdl/scce_queue.sv =====
// Small FIFO of accepted bits between the front and back ends.
// Depends on scce_pkg and assert_macros.svh.
`include "assert_macros.svh"
module scce_queue (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 push_i,
  input  scce_pkg::entry_t     wdata_i,
  output logic                 full_o,
  input  logic                 pop_i,
  output scce_pkg::entry_t     rdata_o,
  output logic                 empty_o
);
  import scce_pkg::*;

  entry_t             mem_q [QDepth];
  logic [QPtrW-1:0]   wptr_q, wptr_d;
  logic [QPtrW-1:0]   rptr_q, rptr_d;
  logic [QCntW-1:0]   cnt_q, cnt_d;
  logic               do_push;
  logic               do_pop;

  assign full_o  = (cnt_q == QCntW'(QDepth));
  assign empty_o = (cnt_q == '0);
  assign rdata_o = mem_q[rptr_q];
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && !empty_o;

  always_comb begin
    wptr_d = do_push ? wptr_q + QPtrW'(1) : wptr_q;
    rptr_d = do_pop  ? rptr_q + QPtrW'(1) : rptr_q;
    cnt_d  = cnt_q;
    if (do_push && !do_pop) begin
      cnt_d = cnt_q + QCntW'(1);
    end else if (do_pop && !do_push) begin
      cnt_d = cnt_q - QCntW'(1);
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wptr_q] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q <= '0;
      rptr_q <= '0;
      cnt_q  <= '0;
    end else begin
      wptr_q <= wptr_d;
      rptr_q <= rptr_d;
      cnt_q  <= cnt_d;
    end
  end

  `ASSERT_NEVER(a_q_overfill, clk_i, rst_ni, cnt_q > QCntW'(QDepth))
  `ASSERT_AT(a_q_ptr_gap, clk_i, rst_ni, (QPtrW'(wptr_q - rptr_q) == cnt_q[QPtrW-1:0]))
  `ASSERT_AT(a_q_push_lands, clk_i, rst_ni, (do_push && !do_pop) |=> (cnt_q == $past(cnt_q) + QCntW'(1)))

endmodule

// ===== hdl/scce_back.sv =====
// Back end: serializes echoed data bits and the appended check bits into
// the output register. Depends on scce_pkg and assert_macros.svh.
`include "assert_macros.svh"
module scce_back (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  scce_pkg::entry_t     q_entry_i,
  input  logic                 q_empty_i,
  output logic                 q_pop_o,
  input  logic                 pop_i,
  output logic                 empty_o,
  output logic                 codeword_bit_o,
  output logic                 codeword_end_o,
  output logic                 is_check_bit_o
);
  import scce_pkg::*;

  logic                out_vld_q, out_vld_d;
  logic                out_bit_q, out_bit_d;
  logic                out_end_q, out_end_d;
  logic                out_chk_q, out_chk_d;
  logic [MaxWidth-1:0] sh_q, sh_d;
  logic [WidthW-1:0]   cnt_q, cnt_d;   // check bits still to send
  logic                load;

  assign load = !out_vld_q || pop_i;

  always_comb begin
    out_vld_d = out_vld_q;
    out_bit_d = out_bit_q;
    out_end_d = out_end_q;
    out_chk_d = out_chk_q;
    sh_d      = sh_q;
    cnt_d     = cnt_q;
    q_pop_o   = 1'b0;
    if (load) begin
      if (cnt_q != '0) begin
        out_vld_d = 1'b1;
        out_bit_d = sh_q[MaxWidth-1];
        out_end_d = (cnt_q == WidthW'(1));
        out_chk_d = 1'b1;
        sh_d      = sh_q << 1;
        cnt_d     = cnt_q - WidthW'(1);
      end else if (!q_empty_i) begin
        q_pop_o   = 1'b1;
        out_vld_d = 1'b1;
        out_bit_d = q_entry_i.data;
        out_end_d = 1'b0;
        out_chk_d = 1'b0;
        if (q_entry_i.last) begin
          sh_d  = q_entry_i.rem_al;
          cnt_d = q_entry_i.width;
        end
      end else begin
        out_vld_d = 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    out_bit_q <= out_bit_d;
    out_end_q <= out_end_d;
    out_chk_q <= out_chk_d;
    sh_q      <= sh_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
      cnt_q     <= '0;
    end else begin
      out_vld_q <= out_vld_d;
      cnt_q     <= cnt_d;
    end
  end

  assign empty_o        = !out_vld_q;
  assign codeword_bit_o = out_bit_q;
  assign codeword_end_o = out_end_q;
  assign is_check_bit_o = out_chk_q;

  `ASSERT_NEVER(a_cnt_range, clk_i, rst_ni, cnt_q > WidthW'(MaxWidth))
  `ASSERT_NEVER(a_no_pop_midcheck, clk_i, rst_ni, q_pop_o && (cnt_q != '0))
  `ASSERT_AT(a_end_is_check, clk_i, rst_ni, (out_vld_q && out_end_q) |-> out_chk_q)

endmodule

// ===== hdl/serial_crc_codeword_encoder_unit.sv =====
// Serial CRC codeword encoder: message bits in, data echoed, then the remainder
// bits after the last bit. An accepted bit passes through the queue and then the
// output register before it can be popped. Throughput: one bit in and one result
// out per cycle unless a full queue or a held pop stalls; a message of n bits
// yields n + width results, so the output port sets the sustained input rate.
// Reset (rst_ni, async low): gen_poly=3, crc_width=4, remainder zero, queue and output register empty.
module serial_crc_codeword_encoder_unit (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [1:0]  cfg_index_i,
  input  logic [31:0] cfg_data_i,
  input  logic        push,
  output logic        full,
  input  logic        data_bit_i,
  input  logic        last_bit_i,
  output logic        empty,
  input  logic        pop,
  output logic        codeword_bit_o,
  output logic        codeword_end_o,
  output logic        is_check_bit_o
);
  import scce_pkg::*;

  logic   q_push;
  logic   q_full;
  entry_t wr_entry;
  entry_t rd_entry;
  logic   q_empty;
  logic   q_pop;

  scce_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_valid_i (cfg_valid_i),
    .cfg_ready_o (cfg_ready_o),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .push_i      (push),
    .data_bit_i  (data_bit_i),
    .last_bit_i  (last_bit_i),
    .q_full_i    (q_full),
    .q_push_o    (q_push),
    .q_entry_o   (wr_entry)
  );

  scce_queue u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (q_push),
    .wdata_i (wr_entry),
    .full_o  (q_full),
    .pop_i   (q_pop),
    .rdata_o (rd_entry),
    .empty_o (q_empty)
  );

  scce_back u_back (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .q_entry_i      (rd_entry),
    .q_empty_i      (q_empty),
    .q_pop_o        (q_pop),
    .pop_i          (pop),
    .empty_o        (empty),
    .codeword_bit_o (codeword_bit_o),
    .codeword_end_o (codeword_end_o),
    .is_check_bit_o (is_check_bit_o)
  );

  assign full = q_full;

endmodule

// ===== bench/testbench.sv =====
// Self-checking bench for serial_crc_codeword_encoder_unit: bit-serial CRC codeword checks.
// Depends on scce_pkg (config indexes, MaxWidth) and on the encoder RTL.
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  import scce_pkg::*;

  localparam logic [1:0]  SpareIdxA    = 2'd2;
  localparam logic [1:0]  SpareIdxB    = 2'd3;
  localparam int unsigned SettleCycles = 8;
  localparam int unsigned HoldCycles   = 120;
  localparam int unsigned RandomItems  = 115;

  typedef struct packed {
    logic cw_bit;
    logic cw_end;
    logic is_check;
  } codeword_bit_t;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        cfg_valid = 1'b0;
  logic        cfg_ready_o;
  logic [1:0]  cfg_index = 2'd0;
  logic [31:0] cfg_data = 32'd0;
  logic        push = 1'b0;
  logic        full;
  logic        data_bit = 1'b0;
  logic        last_bit = 1'b0;
  logic        empty;
  logic        pop = 1'b0;
  logic        codeword_bit_o;
  logic        codeword_end_o;
  logic        is_check_bit_o;

  // predictor state, mirrors the block's registers
  logic [31:0] gen_poly_q  = 32'd3;
  logic [5:0]  crc_width_q = 6'd4;
  logic [31:0] rem_q       = 32'd0;
  codeword_bit_t codeword_q[$];

  logic        check_failed = 1'b0;
  logic        hold_req = 1'b0;
  int unsigned stall_left = 0;
  int unsigned run_left = 0;
  int unsigned pop_pick;
  codeword_bit_t want;

  serial_crc_codeword_encoder_unit DUT (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_valid_i    (cfg_valid),
    .cfg_ready_o    (cfg_ready_o),
    .cfg_index_i    (cfg_index),
    .cfg_data_i     (cfg_data),
    .push           (push),
    .full           (full),
    .data_bit_i     (data_bit),
    .last_bit_i     (last_bit),
    .empty          (empty),
    .pop            (pop),
    .codeword_bit_o (codeword_bit_o),
    .codeword_end_o (codeword_end_o),
    .is_check_bit_o (is_check_bit_o)
  );

  always begin
    #6 clk_i = 1'b1;
    #6 clk_i = 1'b0;
  end

  initial begin
    #40ms;
    $display("testbench NOT OK");
    $finish;
  end

  // One division step per accepted bit; queues the echoed bit and, on the
  // last bit, the remainder bits MSB first.
  function automatic void encode_bit(input logic d, input logic last);
    int unsigned w;
    int unsigned i;
    logic [63:0] mask;
    logic [63:0] rem;
    logic        fb;
    w = (crc_width_q == 6'd0) ? 1 : (crc_width_q > MaxWidth ? MaxWidth : crc_width_q);
    mask = (64'd1 << w) - 64'd1;
    rem = {32'd0, rem_q} & mask;
    fb = rem[w-1] ^ d;
    rem = (rem << 1) & mask;
    if (fb) rem = rem ^ ({32'd0, gen_poly_q} & mask);
    rem_q = rem[31:0];
    codeword_q.push_back('{cw_bit: d, cw_end: 1'b0, is_check: 1'b0});
    if (last) begin
      for (i = 0; i < w; i++) begin
        codeword_q.push_back('{cw_bit: rem[w-1-i], cw_end: (i == w - 1), is_check: 1'b1});
      end
      rem_q = 32'd0;
    end
  endfunction

  // Receiver: checks each popped item and throttles pop.
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (pop && !empty) begin
        if (codeword_q.size() == 0) begin
          $error("unexpected codeword item: bit %0b end %0b check %0b",
                 codeword_bit_o, codeword_end_o, is_check_bit_o);
          check_failed = 1'b1;
        end else begin
          want = codeword_q.pop_front();
          if (codeword_bit_o !== want.cw_bit) begin
            $error("codeword_bit: expected %0b, got %0b", want.cw_bit, codeword_bit_o);
            check_failed = 1'b1;
          end
          if (codeword_end_o !== want.cw_end) begin
            $error("codeword_end: expected %0b, got %0b", want.cw_end, codeword_end_o);
            check_failed = 1'b1;
          end
          if (is_check_bit_o !== want.is_check) begin
            $error("is_check_bit: expected %0b, got %0b", want.is_check, is_check_bit_o);
            check_failed = 1'b1;
          end
        end
      end
      if (hold_req) begin
        stall_left = HoldCycles;
        run_left = 0;
        hold_req <= 1'b0;
      end
      if (stall_left > 0) begin
        stall_left--;
        pop <= 1'b0;
      end else if (run_left > 0) begin
        run_left--;
        pop <= 1'b1;
      end else begin
        pop_pick = $urandom_range(0, 31);
        if (pop_pick == 0) stall_left = $urandom_range(15, 50);
        else if (pop_pick < 8) stall_left = $urandom_range(1, 3);
        else if (pop_pick < 10) run_left = $urandom_range(30, 80);
        pop <= (stall_left == 0);
      end
    end
  end

  task automatic cfg_write(input logic [1:0] idx, input logic [31:0] value);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= value;
    do @(posedge clk_i); while (!cfg_ready_o);
    cfg_valid <= 1'b0;
    case (idx)
      CfgGenPoly:  gen_poly_q = value;
      CfgCrcWidth: crc_width_q = value[5:0];
      default: ;
    endcase
    @(posedge clk_i);
  endtask

  // push stays high afterwards; sender_gap or wait_idle lowers it
  task automatic send_bit(input logic d, input logic last);
    push     <= 1'b1;
    data_bit <= d;
    last_bit <= last;
    do @(posedge clk_i); while (full);
    encode_bit(d, last);
  endtask

  task automatic sender_gap();
    int unsigned pick;
    pick = $urandom_range(0, 15);
    if (pick >= 9) begin
      push <= 1'b0;
      repeat (pick == 15 ? $urandom_range(12, 40) : $urandom_range(1, 3)) @(posedge clk_i);
    end
  endtask

  task automatic wait_idle();
    push <= 1'b0;
    @(posedge clk_i);
    while (codeword_q.size() != 0) @(posedge clk_i);
    repeat (SettleCycles) @(posedge clk_i);
  endtask

  task automatic send_msg(input logic [31:0] bits, input int unsigned len);
    int unsigned i;
    for (i = len; i > 0; i--) begin
      send_bit(bits[i-1], i == 1);
      sender_gap();
    end
  endtask

  task automatic test_default_crc();
    send_msg(32'b1, 1);
    send_msg(32'b0, 1);
    send_msg(32'b110101, 6);
    wait_idle();
  endtask

  // width 0 acts as 1, widths past 32 clamp to 32; all-ones and zero generators
  task automatic test_width_limits();
    cfg_write(CfgCrcWidth, 32'd0);
    send_msg(32'b11, 2);
    wait_idle();
    cfg_write(CfgGenPoly, 32'hFFFF_FFFF);
    cfg_write(CfgCrcWidth, 32'd32);
    send_msg(32'b101, 3);
    wait_idle();
    cfg_write(CfgCrcWidth, 32'hFFFF_FFFF);
    cfg_write(CfgGenPoly, 32'h04C1_1DB7);
    send_msg(32'b1, 1);
    wait_idle();
    cfg_write(CfgGenPoly, 32'd0);
    cfg_write(CfgCrcWidth, 32'd5);
    send_msg(32'b10, 2);
    wait_idle();
  endtask

  task automatic test_spare_index();
    cfg_write(SpareIdxA, $urandom());
    cfg_write(SpareIdxB, $urandom());
    send_msg(32'b01, 2);
    wait_idle();
  endtask

  // remainder gets masked to the new width partway through a message
  task automatic test_mid_message_config();
    cfg_write(CfgGenPoly, 32'h07);
    cfg_write(CfgCrcWidth, 32'd8);
    send_bit(1'b1, 1'b0);
    send_bit(1'b1, 1'b0);
    send_bit(1'b0, 1'b0);
    wait_idle();
    cfg_write(CfgCrcWidth, 32'd3);
    send_bit(1'b1, 1'b0);
    send_bit(1'b0, 1'b1);
    wait_idle();
  endtask

  // receiver holds off while items keep coming, then the sender drains fully
  task automatic test_output_stall();
    int unsigned i;
    cfg_write(CfgCrcWidth, 32'd16);
    cfg_write(CfgGenPoly, 32'h1021);
    hold_req <= 1'b1;
    for (i = 0; i < 24; i++) send_bit(1'($urandom_range(0, 1)), (i % 8) == 7);
    wait_idle();
    for (i = 0; i < 6; i++) begin
      send_bit(1'($urandom_range(0, 1)), i == 5);
      sender_gap();
    end
    wait_idle();
  endtask

  task automatic test_random_traffic();
    int unsigned n;
    int unsigned i;
    int unsigned phase_len;
    int unsigned pick;
    logic [5:0]  w;
    n = 0;
    while (n < RandomItems) begin
      wait_idle();
      pick = $urandom_range(0, 9);
      if (pick == 0) w = 6'd0;
      else if (pick == 1) w = 6'($urandom_range(33, 63));
      else if (pick == 2) w = 6'd32;
      else w = 6'($urandom_range(1, 8));
      pick = $urandom_range(0, 3);
      if (pick != 1) cfg_write(CfgCrcWidth, ($urandom() & 32'hFFFF_FFC0) | {26'd0, w});
      if (pick != 0) cfg_write(CfgGenPoly, $urandom());
      if (pick == 3) cfg_write($urandom_range(0, 1) ? SpareIdxA : SpareIdxB, $urandom());
      phase_len = $urandom_range(10, 30);
      for (i = 0; i < phase_len; i++) begin
        send_bit(1'($urandom_range(0, 1)), $urandom_range(0, 5) == 0);
        sender_gap();
      end
      n += phase_len;
    end
    send_bit(1'($urandom_range(0, 1)), 1'b1);
    wait_idle();
  endtask

  initial begin
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    test_default_crc();
    test_width_limits();
    test_spare_index();
    test_mid_message_config();
    test_output_stall();
    test_random_traffic();
    wait_idle();
    if (!check_failed) $display("testbench OK");
    else $display("testbench NOT OK");
    $finish;
  end

endmodule

// ===== files.f =====
+incdir+hdl
hdl/scce_pkg.sv
hdl/scce_front.sv
hdl/scce_queue.sv
hdl/scce_back.sv
hdl/serial_crc_codeword_encoder_unit.sv
bench/testbench.sv
